>>> design/s20_pkg.sv
// Shared types, constants and microcode program for the Salsa20 stream cipher core.
package s20_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned STEP_W = 4;

  typedef logic [3:0] widx_t;

  localparam logic [WORD_W-1:0] SIGMA [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };

  localparam widx_t COL_IDX [4][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1 },
    '{4'd10, 4'd14, 4'd2,  4'd6 },
    '{4'd15, 4'd3,  4'd7,  4'd11}
  };

  localparam widx_t ROW_IDX [4][4] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3 },
    '{4'd5,  4'd6,  4'd7,  4'd4 },
    '{4'd10, 4'd11, 4'd8,  4'd9 },
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  localparam logic [4:0] ROT_AMT [4] = '{5'd7, 5'd9, 5'd13, 5'd18};

  // configuration register indexes
  localparam logic [2:0] CFG_KEY01 = 3'd0;
  localparam logic [2:0] CFG_KEY23 = 3'd1;
  localparam logic [2:0] CFG_KEY45 = 3'd2;
  localparam logic [2:0] CFG_KEY67 = 3'd3;
  localparam logic [2:0] CFG_NONCE = 3'd4;

  typedef enum logic [1:0] {
    UOP_LOAD,
    UOP_QR,
    UOP_FEED,
    UOP_END
  } uop_e;

  typedef struct packed {
    uop_e       op;
    logic       row;
    logic [1:0] sub;
    logic       loop;
  } ucode_t;

  typedef struct packed {
    logic       load;
    logic       qr;
    logic       row;
    logic [1:0] sub;
    logic       feed;
  } ctl_t;

  localparam logic [STEP_W-1:0] LOOP_TARGET = 4'd1;

  // program: load, column round steps, row round steps (loop back), feed-forward, end
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{op: UOP_END, row: 1'b0, sub: 2'd0, loop: 1'b0};
    unique case (step)
      4'd0:    w = '{op: UOP_LOAD, row: 1'b0, sub: 2'd0, loop: 1'b0};
      4'd1:    w = '{op: UOP_QR,   row: 1'b0, sub: 2'd0, loop: 1'b0};
      4'd2:    w = '{op: UOP_QR,   row: 1'b0, sub: 2'd1, loop: 1'b0};
      4'd3:    w = '{op: UOP_QR,   row: 1'b0, sub: 2'd2, loop: 1'b0};
      4'd4:    w = '{op: UOP_QR,   row: 1'b0, sub: 2'd3, loop: 1'b0};
      4'd5:    w = '{op: UOP_QR,   row: 1'b1, sub: 2'd0, loop: 1'b0};
      4'd6:    w = '{op: UOP_QR,   row: 1'b1, sub: 2'd1, loop: 1'b0};
      4'd7:    w = '{op: UOP_QR,   row: 1'b1, sub: 2'd2, loop: 1'b0};
      4'd8:    w = '{op: UOP_QR,   row: 1'b1, sub: 2'd3, loop: 1'b1};
      4'd9:    w = '{op: UOP_FEED, row: 1'b0, sub: 2'd0, loop: 1'b0};
      default: w = '{op: UOP_END,  row: 1'b0, sub: 2'd0, loop: 1'b0};
    endcase
    return w;
  endfunction

endpackage

>>> design/s20_stream_if.sv
// Valid/ready stream interfaces for the message and cipher word channels.
interface s20_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        last_word;

  modport source (output valid, output msg_word, output last_word, input ready);
  modport sink   (input valid, input msg_word, input last_word, output ready);
endinterface

interface s20_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic        last_out;

  modport source (output valid, output cipher_word, output last_out, input ready);
  modport sink   (input valid, input cipher_word, input last_out, output ready);
endinterface

>>> design/s20_qstep.sv
// One quarter-round step: add, rotate left, xor into the target word.
module s20_qstep import s20_pkg::*; (
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  input  logic [WORD_W-1:0] t_i,
  input  logic [4:0]        rot_i,
  output logic [WORD_W-1:0] res_o
);

  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] rot;

  assign sum   = a_i + b_i;
  assign rot   = (sum << rot_i) | (sum >> (6'd32 - {1'b0, rot_i}));
  assign res_o = rot ^ t_i;

endmodule

>>> design/s20_seq.sv
// Microcode sequencer: step counter, program ROM and double-round loop counter.
module s20_seq import s20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output ctl_t ctl_o,
  output logic done_o
);

  localparam int unsigned RW = $clog2(DOUBLE_ROUNDS + 1);

  logic              run_q, run_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RW-1:0]     rnd_q, rnd_d;
  ucode_t            uw;

  assign uw = ucode_rom(step_q);

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    rnd_d  = rnd_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
    end else if (run_q) begin
      if (uw.op == UOP_LOAD) begin
        rnd_d = RW'(DOUBLE_ROUNDS);
      end
      if (uw.op == UOP_END) begin
        run_d = 1'b0;
      end else if (uw.loop && (rnd_q != RW'(1))) begin
        step_d = LOOP_TARGET;
        rnd_d  = rnd_q - RW'(1);
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= '0;
      rnd_q  <= '0;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
      rnd_q  <= rnd_d;
    end
  end

  assign ctl_o.load = run_q && (uw.op == UOP_LOAD);
  assign ctl_o.qr   = run_q && (uw.op == UOP_QR);
  assign ctl_o.feed = run_q && (uw.op == UOP_FEED);
  assign ctl_o.row  = uw.row;
  assign ctl_o.sub  = uw.sub;
  assign done_o     = run_q && (uw.op == UOP_END);

endmodule

>>> design/s20_datapath.sv
// Round datapath: working matrix, four quarter-round step units, keystream block store.
module s20_datapath import s20_pkg::*; (
  input  logic              clk_i,
  input  ctl_t              ctl_i,
  input  logic [CFG_W-1:0]  key01_i,
  input  logic [CFG_W-1:0]  key23_i,
  input  logic [CFG_W-1:0]  key45_i,
  input  logic [CFG_W-1:0]  key67_i,
  input  logic [CFG_W-1:0]  nonce_i,
  input  logic [CFG_W-1:0]  ctr_i,
  input  logic [3:0]        ks_idx_i,
  output logic [WORD_W-1:0] ks_word_o
);

  logic [WORD_W-1:0] st_q [16];
  logic [WORD_W-1:0] st_d [16];
  logic [WORD_W-1:0] ks_q [16];
  logic [WORD_W-1:0] init_w [16];
  logic [WORD_W-1:0] nx_w [4];
  widx_t             tgt_w [4];

  always_comb begin
    init_w[0]  = SIGMA[0];
    init_w[1]  = key01_i[31:0];
    init_w[2]  = key01_i[63:32];
    init_w[3]  = key23_i[31:0];
    init_w[4]  = key23_i[63:32];
    init_w[5]  = SIGMA[1];
    init_w[6]  = nonce_i[31:0];
    init_w[7]  = nonce_i[63:32];
    init_w[8]  = ctr_i[31:0];
    init_w[9]  = ctr_i[63:32];
    init_w[10] = SIGMA[2];
    init_w[11] = key45_i[31:0];
    init_w[12] = key45_i[63:32];
    init_w[13] = key67_i[31:0];
    init_w[14] = key67_i[63:32];
    init_w[15] = SIGMA[3];
  end

  for (genvar j = 0; j < 4; j++) begin : g_unit
    widx_t ia, ib, it;
    always_comb begin
      if (ctl_i.row) begin
        ia = ROW_IDX[j][ctl_i.sub];
        ib = ROW_IDX[j][2'(ctl_i.sub + 2'd3)];
        it = ROW_IDX[j][2'(ctl_i.sub + 2'd1)];
      end else begin
        ia = COL_IDX[j][ctl_i.sub];
        ib = COL_IDX[j][2'(ctl_i.sub + 2'd3)];
        it = COL_IDX[j][2'(ctl_i.sub + 2'd1)];
      end
    end
    assign tgt_w[j] = it;
    s20_qstep u_qstep (
      .a_i   (st_q[ia]),
      .b_i   (st_q[ib]),
      .t_i   (st_q[it]),
      .rot_i (ROT_AMT[ctl_i.sub]),
      .res_o (nx_w[j])
    );
  end

  always_comb begin
    st_d = st_q;
    if (ctl_i.load) begin
      st_d = init_w;
    end else if (ctl_i.qr) begin
      for (int j = 0; j < 4; j++) begin
        st_d[tgt_w[j]] = nx_w[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (ctl_i.feed) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= st_q[i] + init_w[i];
      end
    end
  end

  assign ks_word_o = ks_q[ks_idx_i];

endmodule

>>> design/salsa20_stream_cipher_core.sv
// Top level of the Salsa20/20 stream cipher core.
// Usage: load the key (four 64-bit registers) and nonce through the config
// write port while idle, then stream 32-bit message words on in_if. Each word
// comes back on out_if XORed with the keystream, first byte in bits 7..0.
// last_word marks the end of a message; the block counter and word position
// then return to zero so the next message starts at keystream block 0.
// Keystream: the first word of every 64-byte block starts a keystream block,
// which the microcode sequencer runs as one load step, 8 steps per double
// round (four quarter-round units, one add-rotate-xor step each), a
// feed-forward step and an end step that loads the output register. The
// other 15 words of a block come out in the cycle after their transfer.
// One word is in flight at a time; the next word is taken in the same cycle
// the previous result is taken.
// Reset clears the registers, counter, position and output valid. When the
// receiver stalls the result holds in the output register and in_if.ready
// stays low until it is transferred.
module salsa20_stream_cipher_core import s20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  s20_in_if.sink           in_if,
  s20_out_if.source        out_if
);

  logic [CFG_W-1:0]  key01_q, key23_q, key45_q, key67_q, nonce_q;
  logic [CFG_W-1:0]  ctr_q, ctr_d;
  logic [3:0]        pos_q, pos_d;
  logic              busy_q, busy_d;
  logic              out_vld_q, out_vld_d;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q;
  logic [WORD_W-1:0] msg_q;
  logic              last_q;

  logic              in_rdy, acc, new_blk, out_load, seq_done, lst;
  logic [WORD_W-1:0] msg, ks_word;
  ctl_t              ctl;

  assign in_rdy      = !busy_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = in_rdy;
  assign acc         = in_if.valid && in_rdy;
  assign new_blk     = acc && (pos_q == 4'd0);
  assign out_load    = (acc && (pos_q != 4'd0)) || seq_done;
  assign msg         = seq_done ? msg_q : in_if.msg_word;
  assign lst         = seq_done ? last_q : in_if.last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q <= '0;
      key23_q <= '0;
      key45_q <= '0;
      key67_q <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY01: key01_q <= cfg_wdata_i;
        CFG_KEY23: key23_q <= cfg_wdata_i;
        CFG_KEY45: key45_q <= cfg_wdata_i;
        CFG_KEY67: key67_q <= cfg_wdata_i;
        CFG_NONCE: nonce_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ctr_d     = ctr_q;
    pos_d     = pos_q;
    busy_d    = busy_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && out_if.ready) begin
      out_vld_d = 1'b0;
    end
    if (new_blk) begin
      busy_d = 1'b1;
    end
    if (seq_done) begin
      busy_d = 1'b0;
    end
    if (out_load) begin
      out_vld_d = 1'b1;
      if (lst) begin
        ctr_d = '0;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 4'd1;
        if (pos_q == 4'd15) begin
          ctr_d = ctr_q + CFG_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q     <= '0;
      pos_q     <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ctr_q     <= ctr_d;
      pos_q     <= pos_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      msg_q  <= in_if.msg_word;
      last_q <= in_if.last_word;
    end
    if (out_load) begin
      out_word_q <= msg ^ ks_word;
      out_last_q <= lst;
    end
  end

  s20_seq #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (new_blk),
    .ctl_o   (ctl),
    .done_o  (seq_done)
  );

  s20_datapath u_datapath (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .key01_i   (key01_q),
    .key23_i   (key23_q),
    .key45_i   (key45_q),
    .key67_i   (key67_q),
    .nonce_i   (nonce_q),
    .ctr_i     (ctr_q),
    .ks_idx_i  (pos_q),
    .ks_word_o (ks_word)
  );

  assign out_if.valid       = out_vld_q;
  assign out_if.cipher_word = out_word_q;
  assign out_if.last_out    = out_last_q;

endmodule

>>> tb/sv/tb_salsa20_stream_cipher_core.sv
// Testbench for the Salsa20/20 stream core: directed table plus random messages checked by a predictor.
module tb_salsa20_stream_cipher_core import s20_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DR          = 10;
  localparam int          PHASES      = 8;
  localparam int          PHASE_WORDS = 100;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic [WORD_W-1:0] msg;
    logic              last;
  } msg_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] cipher;
    logic              last;
  } cipher_res_t;

  // single-word messages, one full block, a block boundary, last mid-block, a dangling word
  localparam msg_item_t DIRECTED [21] = '{
    '{32'h00000000, 1'b1}, '{32'hffffffff, 1'b1},
    '{32'h00000000, 1'b0}, '{32'hffffffff, 1'b0}, '{32'haaaaaaaa, 1'b0}, '{32'h55555555, 1'b0},
    '{32'h00000001, 1'b0}, '{32'h80000000, 1'b0}, '{32'h7fffffff, 1'b0}, '{32'hfffffffe, 1'b0},
    '{32'h01234567, 1'b0}, '{32'h89abcdef, 1'b0}, '{32'h0000ffff, 1'b0}, '{32'hffff0000, 1'b0},
    '{32'h00ff00ff, 1'b0}, '{32'hff00ff00, 1'b0}, '{32'h12345678, 1'b0}, '{32'hdeadbeef, 1'b0},
    '{32'h00000000, 1'b0}, '{32'hffffffff, 1'b1},
    '{32'h00000000, 1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [2:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  s20_in_if  msg_ch ();
  s20_out_if ct_ch ();

  salsa20_stream_cipher_core #(.DOUBLE_ROUNDS(DR)) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (msg_ch),
    .out_if      (ct_ch)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [CFG_W-1:0]  cfg_shadow [5];
  logic [63:0]       ks_ctr;
  logic [3:0]        ks_pos;
  logic [WORD_W-1:0] ks_words [16];
  logic [WORD_W-1:0] mix_st [16];

  cipher_res_t pending_q [$];
  cipher_res_t want_res;
  cipher_res_t new_res;

  int  words_sent;
  int  words_back;
  int  errors;
  int  idle_cnt;
  int  burst_left;
  int  rx_left;
  bit  tx_free;
  bit  rx_free;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void quarter_round(input int a, input int b, input int c, input int d);
    mix_st[b] ^= rotl(mix_st[a] + mix_st[d], 7);
    mix_st[c] ^= rotl(mix_st[b] + mix_st[a], 9);
    mix_st[d] ^= rotl(mix_st[c] + mix_st[b], 13);
    mix_st[a] ^= rotl(mix_st[d] + mix_st[c], 18);
  endfunction

  function automatic void refill_keystream();
    logic [WORD_W-1:0] init [16];
    init[0]  = SIGMA[0];
    init[1]  = cfg_shadow[CFG_KEY01][31:0];
    init[2]  = cfg_shadow[CFG_KEY01][63:32];
    init[3]  = cfg_shadow[CFG_KEY23][31:0];
    init[4]  = cfg_shadow[CFG_KEY23][63:32];
    init[5]  = SIGMA[1];
    init[6]  = cfg_shadow[CFG_NONCE][31:0];
    init[7]  = cfg_shadow[CFG_NONCE][63:32];
    init[8]  = ks_ctr[31:0];
    init[9]  = ks_ctr[63:32];
    init[10] = SIGMA[2];
    init[11] = cfg_shadow[CFG_KEY45][31:0];
    init[12] = cfg_shadow[CFG_KEY45][63:32];
    init[13] = cfg_shadow[CFG_KEY67][31:0];
    init[14] = cfg_shadow[CFG_KEY67][63:32];
    init[15] = SIGMA[3];
    for (int i = 0; i < 16; i++) mix_st[i] = init[i];
    for (int r = 0; r < DR; r++) begin
      quarter_round(0, 4, 8, 12);
      quarter_round(5, 9, 13, 1);
      quarter_round(10, 14, 2, 6);
      quarter_round(15, 3, 7, 11);
      quarter_round(0, 1, 2, 3);
      quarter_round(5, 6, 7, 4);
      quarter_round(10, 11, 8, 9);
      quarter_round(15, 12, 13, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix_st[i] + init[i];
  endfunction

  function automatic logic [WORD_W-1:0] next_cipher(input logic [WORD_W-1:0] msg, input logic last);
    logic [WORD_W-1:0] c;
    if (ks_pos == 4'd0) refill_keystream();
    c = msg ^ ks_words[ks_pos];
    if (last) begin
      ks_ctr = '0;
      ks_pos = '0;
    end else begin
      ks_pos = ks_pos + 4'd1;
      if (ks_pos == 4'd0) ks_ctr = ks_ctr + 64'd1;
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    if (idx <= CFG_NONCE) cfg_shadow[idx] = val;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w, input logic l);
    if (!tx_free && burst_left == 0) begin
      msg_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    msg_ch.valid     <= 1'b1;
    msg_ch.msg_word  <= w;
    msg_ch.last_word <= l;
    do @(posedge clk_i); while (!msg_ch.ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (words_back != words_sent);
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else if (!rx_free && ct_ch.ready) begin
      ct_ch.ready <= 1'b0;
      rx_left     <= $urandom_range(0, 7);
    end else begin
      ct_ch.ready <= 1'b1;
      rx_left     <= $urandom_range(0, 15);
    end
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (ct_ch.valid && ct_ch.ready) begin
        words_back++;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result: cipher %h last %b", ct_ch.cipher_word, ct_ch.last_out);
        end else begin
          want_res = pending_q.pop_front();
          if (want_res.cipher !== ct_ch.cipher_word || want_res.last !== ct_ch.last_out) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: cipher exp %h got %h, last exp %b got %b",
                       want_res.cipher, ct_ch.cipher_word, want_res.last, ct_ch.last_out);
          end
        end
      end
      if (msg_ch.valid && msg_ch.ready) begin
        new_res.cipher = next_cipher(msg_ch.msg_word, msg_ch.last_word);
        new_res.last   = msg_ch.last_word;
        pending_q.push_back(new_res);
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((msg_ch.valid && msg_ch.ready) || (ct_ch.valid && ct_ch.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int len;
    int pause_at;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_KEY01;
    cfg_wdata        = '0;
    msg_ch.valid     = 1'b0;
    msg_ch.msg_word  = '0;
    msg_ch.last_word = 1'b0;
    ct_ch.ready      = 1'b0;
    for (int r = 0; r <= CFG_NONCE; r++) cfg_shadow[r] = '0;
    for (int i = 0; i < 16; i++) ks_words[i] = '0;
    ks_ctr     = '0;
    ks_pos     = '0;
    words_sent = 0;
    words_back = 0;
    errors     = 0;
    idle_cnt   = 0;
    burst_left = 0;
    rx_left    = 0;
    tx_free    = 1'b0;
    rx_free    = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_word(DIRECTED[i].msg, DIRECTED[i].last);
    msg_ch.valid <= 1'b0;
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      // first two phases hit the all-ones and all-zeros extremes
      for (int r = 0; r <= CFG_NONCE; r++) begin
        if (ph < 3 || $urandom_range(0, 1))
          write_reg(3'(r), (ph == 0) ? {CFG_W{1'b1}} : (ph == 1) ? {CFG_W{1'b0}} : pick_reg());
      end
      write_reg(3'(CFG_NONCE + 1 + $urandom_range(0, 2)), pick_reg());
      cfg_we  <= 1'b0;
      tx_free = (ph % 3 == 2);
      rx_free = (ph % 4 == 3);

      n        = 0;
      pause_at = $urandom_range(10, PHASE_WORDS - 10);
      while (n < PHASE_WORDS) begin
        case ($urandom_range(0, 9)) inside
          [0:1]:   len = $urandom_range(1, 3);
          [2:5]:   len = $urandom_range(4, 17);
          default: len = $urandom_range(15, 40);
        endcase
        if (len > PHASE_WORDS - n) len = PHASE_WORDS - n;
        for (int k = 0; k < len; k++) begin
          if (n == pause_at) begin
            msg_ch.valid <= 1'b0;
            wait_drained();
          end
          // odd phases stop mid-block so the next key takes over mid-stream
          send_word(pick_word(), (k == len - 1) && !(ph % 2 == 1 && n == PHASE_WORDS - 1));
          n++;
        end
      end
      msg_ch.valid <= 1'b0;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    errors += pending_q.size();
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
